// File: design/fbdsf_pkg.sv
package fbdsf_pkg;

   typedef enum logic [1:0] {
      OP_DRAW   = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_COMMIT = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   localparam int          SEG_COLS        = 16;
   localparam logic [7:0]  CMD_PAGE_BASE   = 8'hB0;
   localparam logic [7:0]  CMD_COL_LO_MASK = 8'h0F;
   localparam logic [7:0]  CMD_COL_HI_BASE = 8'h10;
   localparam logic [7:0]  BYTE_ALL_ONES   = 8'hFF;

   localparam logic [1:0]  CMD_IDX_PAGE    = 2'd0;
   localparam logic [1:0]  CMD_IDX_COL_LO  = 2'd1;
   localparam logic [1:0]  CMD_IDX_COL_HI  = 2'd2;

endpackage

// File: design/fbdsf_if.sv
interface fbdsf_req_if;
   import fbdsf_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] pixel_x;
   logic [7:0] pixel_y;
   logic       pixel_on;
   logic [2:0] page_index;
   logic [2:0] segment_index;

   modport source (
      output valid, operation, pixel_x, pixel_y, pixel_on, page_index, segment_index,
      input  ready
   );
   modport sink (
      input  valid, operation, pixel_x, pixel_y, pixel_on, page_index, segment_index,
      output ready
   );
endinterface

interface fbdsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_command;
   logic       last;

   modport source (
      output valid, out_byte, is_command, last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, is_command, last,
      output ready
   );
endinterface

// File: design/fbdsf_ram.sv
module fbdsf_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/framebuffer_dirty_segment_flush.sv
// Monochrome page-organized framebuffer with dirty-segment flushing.
// req_if (sink) takes one word per operation: draw pixel, clear drawing store,
// commit frame, update segment. rsp_if (source) gives display words: three
// command words and sixteen data words per dirty segment, last on the final one.
// Stores are three single-port-write, registered-read memories of WIDTH*PAGES
// bytes. Everything runs through one sequencer, one operation at a time.
// Steps per operation, with DEPTH = WIDTH*PAGES:
//   draw: read, then modify-write of one drawing byte; an off-screen draw is dropped
//   clear: one zero write per cycle over all DEPTH drawing bytes
//   commit: one read per cycle over all DEPTH bytes, each write in the cycle after
//   update: a compare walk over 16 columns; a dirty segment then sends
//   3 command words and, per data word, a read, then write-back and send
// The result word sits in an output register; when the receiver stalls the
// sequencer holds, and a new request is taken as soon as the sequencer is idle,
// even while the final word still waits.
// After reset the block walks all DEPTH addresses once, zeroing the three
// stores, and takes no request during that walk.
module framebuffer_dirty_segment_flush
   import fbdsf_pkg::*;
#(
   parameter int WIDTH = 128,
   parameter int PAGES = 8
) (
   input  logic               clock,
   input  logic               reset,
   fbdsf_req_if.sink          req_if,
   fbdsf_rsp_if.source        rsp_if
);

   localparam int DEPTH  = WIDTH * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DRAW,
      S_CLEAR,
      S_COPY,
      S_COPY_END,
      S_CMP,
      S_CMP_END,
      S_CMD,
      S_DRD,
      S_DOUT
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [3:0]        col_ff, col_in;
   logic [7:0]        mask_ff, mask_in;
   logic              on_ff, on_in;
   logic [2:0]        page_ff, page_in;
   logic [2:0]        seg_ff, seg_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              cmp_v_ff, cmp_v_in;
   logic              cmp_rng_ff, cmp_rng_in;
   logic              dirty_ff, dirty_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_cmd_ff, rsp_cmd_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              d_we, c_we, s_we;
   logic [ADDR_W-1:0] d_waddr, c_waddr, s_waddr;
   logic [7:0]        d_wdata, c_wdata, s_wdata;
   logic              d_re, c_re, s_re;
   logic [ADDR_W-1:0] d_raddr, c_raddr, s_raddr;
   logic [7:0]        d_rdata, c_rdata, s_rdata;

   logic              req_accept;
   logic              slot_free;
   logic              rsp_load;
   logic              cmp_hit;
   logic [7:0]        col_abs;
   logic              col_ok;
   logic [ADDR_W-1:0] col_addr;
   logic              draw_ok;
   logic [ADDR_W-1:0] draw_addr;
   logic [7:0]        seg_start;
   logic              upd_ok;
   logic [ADDR_W-1:0] upd_base;

   fbdsf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_drawing (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (d_re),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   fbdsf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_committed (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (c_re),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   fbdsf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_shown (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_byte   = rsp_byte_ff;
   assign rsp_if.is_command = rsp_cmd_ff;
   assign rsp_if.last       = rsp_last_ff;

   assign col_abs  = {1'b0, seg_ff, 4'b0000} + {4'b0000, col_ff};
   assign col_ok   = ({1'b0, col_abs} < 9'(WIDTH));
   assign col_addr = addr_ff + ADDR_W'(col_ff);
   assign cmp_hit  = cmp_v_ff && cmp_rng_ff && (c_rdata != s_rdata);

   assign draw_ok   = ({1'b0, req_if.pixel_x} < 9'(WIDTH)) &&
                      ({1'b0, req_if.pixel_y} < 9'(PAGES * 8));
   assign draw_addr = ADDR_W'(req_if.pixel_y[7:3]) * ADDR_W'(WIDTH) +
                      ADDR_W'(8'(WIDTH - 1) - req_if.pixel_x);

   assign seg_start = {1'b0, req_if.segment_index, 4'b0000};
   assign upd_ok    = ({1'b0, req_if.page_index} < 4'(PAGES)) &&
                      ({1'b0, seg_start} < 9'(WIDTH));
   assign upd_base  = ADDR_W'(req_if.page_index) * ADDR_W'(WIDTH) + ADDR_W'(seg_start);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      col_in       = col_ff;
      mask_in      = mask_ff;
      on_in        = on_ff;
      page_in      = page_ff;
      seg_in       = seg_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cmp_v_in     = 1'b0;
      cmp_rng_in   = cmp_rng_ff;
      dirty_in     = dirty_ff | cmp_hit;
      rsp_load     = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;

      d_we    = 1'b0;
      d_waddr = addr_ff;
      d_wdata = '0;
      d_re    = 1'b0;
      d_raddr = addr_ff;
      c_we    = pend_ff;
      c_waddr = pend_addr_ff;
      c_wdata = d_rdata;
      c_re    = 1'b0;
      c_raddr = col_addr;
      s_we    = 1'b0;
      s_waddr = col_addr;
      s_wdata = c_rdata;
      s_re    = 1'b0;
      s_raddr = col_addr;

      unique case (state_ff)
         S_INIT: begin
            d_we    = 1'b1;
            c_we    = 1'b1;
            c_waddr = addr_ff;
            c_wdata = '0;
            s_we    = 1'b1;
            s_waddr = addr_ff;
            s_wdata = '0;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_if.operation)
                  OP_DRAW: begin
                     if (draw_ok) begin
                        d_re     = 1'b1;
                        d_raddr  = draw_addr;
                        addr_in  = draw_addr;
                        mask_in  = 8'b1 << req_if.pixel_y[2:0];
                        on_in    = req_if.pixel_on;
                        state_in = S_DRAW;
                     end
                  end
                  OP_CLEAR: begin
                     addr_in  = '0;
                     state_in = S_CLEAR;
                  end
                  OP_COMMIT: begin
                     addr_in  = '0;
                     state_in = S_COPY;
                  end
                  OP_UPDATE: begin
                     if (upd_ok) begin
                        addr_in  = upd_base;
                        page_in  = req_if.page_index;
                        seg_in   = req_if.segment_index;
                        col_in   = '0;
                        dirty_in = 1'b0;
                        state_in = S_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAW: begin
            d_we     = 1'b1;
            d_wdata  = on_ff ? (d_rdata | mask_ff) : (d_rdata & (mask_ff ^ BYTE_ALL_ONES));
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            d_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_COPY: begin
            d_re         = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = addr_ff;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_COPY_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_COPY_END: begin
            state_in = S_IDLE;
         end
         S_CMP: begin
            c_re       = 1'b1;
            s_re       = 1'b1;
            cmp_v_in   = 1'b1;
            cmp_rng_in = col_ok;
            if (col_ff == 4'(SEG_COLS - 1)) begin
               col_in   = '0;
               state_in = S_CMP_END;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_CMP_END: begin
            col_in   = '0;
            state_in = (dirty_ff || cmp_hit) ? S_CMD : S_IDLE;
         end
         S_CMD: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_cmd_in  = 1'b1;
               rsp_last_in = 1'b0;
               unique case (col_ff[1:0])
                  CMD_IDX_PAGE:   rsp_byte_in = CMD_PAGE_BASE | {5'b0, page_ff};
                  CMD_IDX_COL_LO: rsp_byte_in = CMD_COL_LO_MASK & {1'b0, seg_ff, 4'b0000};
                  default:        rsp_byte_in = CMD_COL_HI_BASE | {5'b0, seg_ff};
               endcase
               if (col_ff[1:0] == CMD_IDX_COL_HI) begin
                  col_in   = '0;
                  state_in = S_DRD;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         S_DRD: begin
            c_re     = 1'b1;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_cmd_in  = 1'b0;
               rsp_byte_in = col_ok ? c_rdata : 8'h00;
               rsp_last_in = (col_ff == 4'(SEG_COLS - 1));
               s_we        = col_ok;
               if (col_ff == 4'(SEG_COLS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         cmp_v_ff     <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         cmp_v_ff     <= cmp_v_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      on_ff        <= on_in;
      page_ff      <= page_in;
      seg_ff       <= seg_in;
      pend_addr_ff <= pend_addr_in;
      cmp_rng_ff   <= cmp_rng_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_shown_write_sends: assert property (@(posedge clock) disable iff (reset)
      (s_we && state_ff != S_INIT) |-> (rsp_load && !rsp_cmd_in))
      else $error("shown store written without sending the data word");

   a_last_ends_transfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == S_IDLE))
      else $error("last word loaded but sequencer did not return to idle");

   a_commit_follows_read: assert property (@(posedge clock) disable iff (reset)
      (c_we && state_ff != S_INIT) |-> $past(state_ff == S_COPY))
      else $error("committed store written outside the copy walk");

   a_no_last_on_command: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_cmd_in && rsp_last_in))
      else $error("command word marked as last");

endmodule
